// ===== sv/i2cps_pkg.sv =====
// Shared types and register indexes for the I2C packet slave.
package i2cps_pkg;

  localparam int unsigned IDX_W = 6;

  localparam logic REG_OWN_ADDR = 1'b0;
  localparam logic REG_STATUS   = 1'b1;

  typedef logic [IDX_W-1:0] idx_t;

  typedef struct packed {
    logic       wr_en;
    idx_t       wr_idx;
    logic [7:0] wr_data;
    logic       build_reply;
    logic       clear_reply;
    idx_t       rd_idx;
  } buf_req_t;

endpackage

// ===== sv/i2cps_buf.sv =====
// Packet buffer: byte memory with registered read and reply overlay.
module i2cps_buf #(
  parameter int unsigned PACKET_BYTES = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  i2cps_pkg::buf_req_t req_i,
  input  logic [7:0]         status_i,
  output logic [7:0]         rd_byte_o
);
  import i2cps_pkg::*;

  localparam int unsigned AW      = $clog2(PACKET_BYTES);
  localparam idx_t        PktIdx  = IDX_W'(PACKET_BYTES);
  localparam idx_t        LastIdx = IDX_W'(PACKET_BYTES - 1);
  localparam logic [7:0]  NByte   = 8'(PACKET_BYTES - 5);
  localparam idx_t        Idx1    = IDX_W'(1);
  localparam idx_t        Idx2    = IDX_W'(2);
  localparam idx_t        Idx3    = IDX_W'(3);

  logic [7:0]    mem [PACKET_BYTES];
  logic [7:0]    mem_q;
  idx_t          rd_idx_q;
  logic [AW-1:0] rd_addr;
  logic          reply_q;
  logic [7:0]    status_q;
  logic [7:0]    reply_byte;

  assign rd_addr = (req_i.rd_idx < PktIdx) ? req_i.rd_idx[AW-1:0] : '0;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.wr_idx[AW-1:0]] <= req_i.wr_data;
    end
    mem_q    <= mem[rd_addr];
    rd_idx_q <= req_i.rd_idx;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reply_q  <= 1'b0;
      status_q <= 8'd0;
    end else if (req_i.build_reply) begin
      reply_q  <= 1'b1;
      status_q <= status_i;
    end else if (req_i.clear_reply) begin
      reply_q  <= 1'b0;
    end
  end

  always_comb begin
    reply_byte = 8'd0;
    if (rd_idx_q == '0) begin
      reply_byte = status_q;
    end else if (rd_idx_q == Idx1) begin
      reply_byte = 8'd0 - status_q;
    end else if (rd_idx_q == Idx2) begin
      reply_byte = 8'd0;
    end else if (rd_idx_q == Idx3) begin
      reply_byte = NByte;
    end else if (rd_idx_q == LastIdx) begin
      reply_byte = 8'd0 - NByte;
    end
  end

  assign rd_byte_o = reply_q ? reply_byte : mem_q;

endmodule

// ===== sv/i2c_packet_slave.sv =====
// Top level: I2C slave event processor with 7-bit address and packet buffer.
// Result path: an accepted input item is registered, then its result is registered (input reg, result reg).
// Throughput: one item per cycle while the output is not stalled; the buffer read port prefetches the next send byte.
// Each item gives exactly one result item.
// Reset clears all control state; SDA drive resets to released (1).
// Buffer bytes are undefined after reset until written.
module i2c_packet_slave #(
  parameter int unsigned PACKET_BYTES = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,  // [0] level, [1] other_level
  input  logic       s_axis_tuser,  // [0] func
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,  // [0] sda_drive, [1] drive_updated, [2] selected
  input  logic       cfg_we_i,
  input  logic       cfg_idx_i,
  input  logic [7:0] cfg_data_i
);
  import i2cps_pkg::*;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_ADDR = 2'd1,
    PH_RECV = 2'd2,
    PH_SEND = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    ACK_NONE   = 2'd0,
    ACK_START  = 2'd1,
    ACK_FINISH = 2'd2
  } ack_e;

  localparam idx_t PktIdx       = IDX_W'(PACKET_BYTES);
  localparam idx_t IdxMax       = '1;

  // config
  logic [6:0] own_addr_q;
  logic [7:0] status_q;

  // input / output registers
  logic       in_vld_q, in_func_q, in_level_q, in_other_q;
  logic       out_vld_q;
  logic [2:0] out_q;
  logic       advance;

  // event state
  phase_e     phase_q, phase_d;
  ack_e       ack_q, ack_d;
  logic       ack_lvl_q, ack_lvl_d;
  logic [7:0] shift_q, shift_d;
  logic [3:0] bits_in_q, bits_in_d;
  logic [2:0] bits_out_q, bits_out_d;
  idx_t       send_idx_q, send_idx_d;
  logic       pending_q, pending_d;
  idx_t       count_q, count_d;
  logic [7:0] sum_q, sum_d;
  logic       drive_q, drive_d;
  logic       ovf_q, ovf_d;
  logic       updated;

  buf_req_t   buf_req;
  logic [7:0] rd_byte;

  assign advance       = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || advance;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {5'd0, out_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_addr_q <= 7'd0;
      status_q   <= 8'd0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_OWN_ADDR: own_addr_q <= cfg_data_i[6:0];
        REG_STATUS:   status_q   <= cfg_data_i;
        default:      ;
      endcase
    end
  end

  always_comb begin
    logic [7:0] sh;
    logic [3:0] bits;
    logic [7:0] byteval;

    phase_d    = phase_q;
    ack_d      = ack_q;
    ack_lvl_d  = ack_lvl_q;
    shift_d    = shift_q;
    bits_in_d  = bits_in_q;
    bits_out_d = bits_out_q;
    send_idx_d = send_idx_q;
    pending_d  = pending_q;
    count_d    = count_q;
    sum_d      = sum_q;
    drive_d    = drive_q;
    ovf_d      = ovf_q;
    updated    = 1'b0;
    sh         = {shift_q[6:0], in_other_q};
    bits       = bits_in_q + 4'd1;
    byteval    = 8'd0;

    buf_req             = '0;
    buf_req.wr_idx      = count_q;
    buf_req.wr_data     = sh;

    if (in_func_q) begin
      if (!in_level_q && in_other_q) begin
        phase_d   = PH_ADDR;
        shift_d   = 8'd0;
        bits_in_d = 4'd0;
      end else if (in_level_q && in_other_q) begin
        phase_d = PH_IDLE;
      end
    end else begin
      if (in_level_q && (phase_q == PH_ADDR || phase_q == PH_RECV) && ack_q == ACK_NONE) begin
        shift_d   = sh;
        bits_in_d = bits;
        if (bits == 4'd8) begin
          if (phase_q == PH_ADDR) begin
            if (sh[7:1] != own_addr_q) begin
              ack_d     = ACK_START;
              ack_lvl_d = 1'b0;
              phase_d   = PH_IDLE;
            end else if (!sh[0]) begin
              count_d     = '0;
              ovf_d       = 1'b0;
              sum_d       = 8'd0;
              ack_d       = ACK_START;
              ack_lvl_d   = 1'b1;
              shift_d     = 8'd0;
              bits_in_d   = 4'd0;
              phase_d     = PH_RECV;
              pending_d   = 1'b1;
              buf_req.clear_reply = 1'b1;
            end else begin
              ack_d     = ACK_START;
              ack_lvl_d = 1'b1;
              if (pending_q) begin
                buf_req.build_reply = (count_q == PktIdx) && !ovf_q;
                pending_d = 1'b0;
              end
              phase_d    = PH_SEND;
              send_idx_d = '0;
              bits_out_d = 3'd0;
            end
          end else begin
            ack_d     = ACK_START;
            ack_lvl_d = 1'b1;
            if (count_q < PktIdx) begin
              buf_req.wr_en = 1'b1;
              count_d       = count_q + IDX_W'(1);
              sum_d         = sum_q + sh;
            end else begin
              ovf_d = 1'b1;
            end
            shift_d   = 8'd0;
            bits_in_d = 4'd0;
          end
        end
      end

      if (!in_level_q && ack_d == ACK_START) begin
        drive_d = !ack_lvl_d;
        ack_d   = ACK_FINISH;
        updated = 1'b1;
      end else if (!in_level_q && ack_d == ACK_FINISH) begin
        drive_d = 1'b1;
        ack_d   = ACK_NONE;
        updated = 1'b1;
      end

      if (!in_level_q && phase_d == PH_SEND && ack_d == ACK_NONE) begin
        if (!(send_idx_q != '0 && bits_out_q == 3'd0 && in_other_q)) begin
          if (send_idx_q < count_q && send_idx_q < PktIdx) begin
            byteval = rd_byte;
          end
          drive_d = byteval[3'd7 - bits_out_q];
          updated = 1'b1;
          if (bits_out_q == 3'd7) begin
            ack_d      = ACK_START;
            ack_lvl_d  = 1'b0;
            bits_out_d = 3'd0;
            if (send_idx_q != IdxMax) begin
              send_idx_d = send_idx_q + IDX_W'(1);
            end
          end else begin
            bits_out_d = bits_out_q + 3'd1;
          end
        end
      end
    end

    if (!advance) begin
      buf_req.wr_en       = 1'b0;
      buf_req.build_reply = 1'b0;
      buf_req.clear_reply = 1'b0;
    end
    buf_req.rd_idx = advance ? send_idx_d : send_idx_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q   <= 1'b0;
      out_vld_q  <= 1'b0;
      phase_q    <= PH_IDLE;
      ack_q      <= ACK_NONE;
      ack_lvl_q  <= 1'b0;
      shift_q    <= 8'd0;
      bits_in_q  <= 4'd0;
      bits_out_q <= 3'd0;
      send_idx_q <= '0;
      pending_q  <= 1'b0;
      count_q    <= '0;
      sum_q      <= 8'd0;
      drive_q    <= 1'b1;
      ovf_q      <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_vld_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_vld_q  <= 1'b1;
        phase_q    <= phase_d;
        ack_q      <= ack_d;
        ack_lvl_q  <= ack_lvl_d;
        shift_q    <= shift_d;
        bits_in_q  <= bits_in_d;
        bits_out_q <= bits_out_d;
        send_idx_q <= send_idx_d;
        pending_q  <= pending_d;
        count_q    <= count_d;
        sum_q      <= sum_d;
        drive_q    <= drive_d;
        ovf_q      <= ovf_d;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_func_q  <= s_axis_tuser;
      in_level_q <= s_axis_tdata[0];
      in_other_q <= s_axis_tdata[1];
    end
    if (advance) begin
      out_q <= {phase_d == PH_RECV || phase_d == PH_SEND, updated, drive_d};
    end
  end

  i2cps_buf #(
    .PACKET_BYTES(PACKET_BYTES)
  ) u_buf (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (buf_req),
    .status_i (status_q),
    .rd_byte_o(rd_byte)
  );

endmodule

// ===== sv/i2cps_chk.sv =====
// Port-level checker for the I2C packet slave, bound to the top level.
module i2cps_chk (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata
);

  logic last_drive_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_drive_q <= 1'b1;
    end else if (m_axis_tvalid && m_axis_tready) begin
      last_drive_q <= m_axis_tdata[0];
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result item changed while stalled");

  a_reset_idle: assert property (@(posedge clk_i) !rst_ni |-> !m_axis_tvalid)
    else $error("result valid during reset");

  a_drive_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !m_axis_tdata[1] |-> m_axis_tdata[0] == last_drive_q)
    else $error("SDA drive changed without update flag");

  a_no_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready |-> s_axis_tready)
    else $error("input stalled while output side is ready");

endmodule

bind i2c_packet_slave i2cps_chk u_chk (.*);
